FILE: sv/bole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 2;
    localparam int POS_FW  = 4;
    localparam int STAT_W  = 2;
    localparam int CNT_FW  = 5;
    localparam int OUT_W   = 1 + POS_FW + STAT_W + CNT_FW;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // Update command broadcast to every cell of the chain
    typedef struct packed {
        logic ins_head;
        logic ins_tail;
        logic del;
    } t_cell_ctrl;

endpackage

FILE: sv/bole_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_cell
// One list slot: holds a value, compares it against the key, shifts toward
// the tail or head on head insert or delete; takes the key on tail insert.
// ----------------------------------------------------------------------------
module bole_cell
    import bole_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmp_en,
    input  logic [VALUE_W-1:0] i_cmp_key,
    input  logic               i_apply,
    input  t_cell_ctrl         i_ctrl,
    input  logic [VALUE_W-1:0] i_key,
    input  logic               i_valid,
    input  logic               i_prev_valid,
    input  logic [VALUE_W-1:0] i_prev_value,
    input  logic [VALUE_W-1:0] i_next_value,
    input  logic               i_hit_in,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_hit_out,
    output logic               o_first
);

    logic [VALUE_W-1:0] r_value;
    logic               r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmp_en) begin
            r_hit <= i_valid && (r_value == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_apply) begin
            priority if (i_ctrl.ins_head) begin
                r_value <= i_prev_value;
            end else if (i_ctrl.ins_tail && !i_valid && i_prev_valid) begin
                r_value <= i_key;
            end else if (i_ctrl.del && o_hit_out) begin
                // close the gap from the first match onward
                r_value <= i_next_value;
            end
        end
    end

    assign o_value   = r_value;
    assign o_hit_out = i_hit_in | r_hit;
    assign o_first   = r_hit & ~i_hit_in;

endmodule

FILE: sv/bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of
// cells: insert at head or tail, search and delete of the first match.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata (low bit first)                     tuser
// s_axis    in         value[31:0]                               op[1:0]
// m_axis    out        found, position[3:0], status[1:0],        -
//                      count[4:0], zero fill to 16 bits
//
// In each transaction the accept cycle registers the parallel compare in
// every cell, then the update state applies the shift and count update
// and loads the result register. The first-match search is a prefix chain
// across the cells. Input is taken again in the cycle after the update, even
// while a result waits; the update cycle holds while the result register is
// still full. Reset (synchronous, active low) empties the list.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [VALUE_W-1:0]     s_axis_tdata,  // value[31:0]
    input  logic [OP_W-1:0]        s_axis_tuser,  // op[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0] m_axis_tdata   // found, position, status, count
);

    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic               r_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [OP_W-1:0]    r_op;
    logic [VALUE_W-1:0] r_key;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic [OUT_W-1:0]   n_out_data;

    logic               w_accept;
    logic               w_go;
    logic               w_full;
    logic               w_empty;
    logic               w_found;
    logic               w_res_found;
    logic [POS_W-1:0]   w_pos;
    logic [POS_FW-1:0]  w_pos_f;
    logic [CNT_FW-1:0]  w_cnt_f;
    logic [STAT_W-1:0]  w_status;
    t_cell_ctrl         w_ctrl;

    logic [VALUE_W-1:0] w_val   [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_first;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_go          = (r_state == ST_UPD) && (!r_out_valid || m_axis_tready);

    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_found = w_hit[CAPACITY-1];

    // report a match only for search and delete
    assign w_res_found = w_found && ((r_op == OP_SEARCH) || (r_op == OP_DELETE));

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = (r_count > CNT_W'(i));
        end
    end

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
        end
    end

    always_comb begin
        w_ctrl.ins_head = (r_op == OP_INS_HEAD) && !w_full;
        w_ctrl.ins_tail = (r_op == OP_INS_TAIL) && !w_full;
        w_ctrl.del      = (r_op == OP_DELETE) && w_found;
    end

    always_comb begin
        n_count = r_count;
        unique case (r_op)
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_status = STAT_OK;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_SEARCH, OP_DELETE: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else if (!w_found) begin
                    w_status = STAT_NOT_FOUND;
                end else begin
                    w_status = STAT_OK;
                    if (r_op == OP_DELETE) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                w_status = STAT_OK;
            end
        endcase
    end

    generate
        if (POS_W >= POS_FW) begin : g_pos_trunc
            assign w_pos_f = w_pos[POS_FW-1:0];
        end else begin : g_pos_ext
            assign w_pos_f = {{(POS_FW-POS_W){1'b0}}, w_pos};
        end
        if (CNT_W >= CNT_FW) begin : g_cnt_trunc
            assign w_cnt_f = n_count[CNT_FW-1:0];
        end else begin : g_cnt_ext
            assign w_cnt_f = {{(CNT_FW-CNT_W){1'b0}}, n_count};
        end
    endgenerate

    assign n_out_data = {w_cnt_f, w_status,
                         (w_res_found ? w_pos_f : {POS_FW{1'b0}}), w_res_found};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (w_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tuser;
            r_key <= s_axis_tdata;
        end
        if (w_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BYTES_W-OUT_W){1'b0}}, r_out_data};

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_W-1:0] w_prev_value;
            logic [VALUE_W-1:0] w_next_value;
            logic               w_prev_valid;
            logic               w_hit_in;

            if (g == 0) begin : g_head
                assign w_prev_value = r_key;
                assign w_prev_valid = 1'b1;
                assign w_hit_in     = 1'b0;
            end else begin : g_body
                assign w_prev_value = w_val[g-1];
                assign w_prev_valid = w_valid[g-1];
                assign w_hit_in     = w_hit[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_next_value = w_val[g];
            end else begin : g_mid
                assign w_next_value = w_val[g+1];
            end

            bole_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmp_en     (w_accept),
                .i_cmp_key    (s_axis_tdata),
                .i_apply      (w_go),
                .i_ctrl       (w_ctrl),
                .i_key        (r_key),
                .i_valid      (w_valid[g]),
                .i_prev_valid (w_prev_valid),
                .i_prev_value (w_prev_value),
                .i_next_value (w_next_value),
                .i_hit_in     (w_hit_in),
                .o_value      (w_val[g]),
                .o_hit_out    (w_hit[g]),
                .o_first      (w_first[g])
            );
        end
    endgenerate

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match");

    a_count_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_go |=> $stable(r_count))
        else $error("count changed outside the update cycle");

    a_found_implies_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) && w_found |-> !w_empty)
        else $error("match reported on empty list");

endmodule
